/* sv/cfr_pkg.sv */
// cfr_pkg: shared types, codes and constants of the checksum frame receiver
// no dependencies; used by the receiver and its checker
`default_nettype none

package cfr_pkg;

   // default frame buffer size in bytes, header and checksum included
   localparam int FRAME_BUFFER_BYTES_DEF = 32;

   // frame sync byte
   localparam logic [7:0] SYNC_BYTE = 8'h5A;

   // result kind codes
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_FINAL
   } cfr_state_type;

endpackage

`default_nettype wire

/* sv/cfr_ram.sv */
// cfr_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies; holds the payload bytes of the frame being received
`default_nettype none

module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 27,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/checksum_frame_receiver.sv */
// checksum_frame_receiver: sync hunt, header capture, payload store and checksum check
// depends on cfr_pkg and cfr_ram
`default_nettype none

// Takes one received byte per word and parses frames of the form
// 5A 5A type length payload[length] checksum, where the checksum is the mod-256
// sum of all earlier frame bytes. A frame with length + 5 above FRAME_BUFFER_BYTES
// is dropped without a result. On a good checksum the payload bytes come out in
// order, followed by an end marker with last set; on a bad one a single error word
// with last set. After every byte except the checksum byte the block stays ready. After
// the checksum byte the block is busy: for a good frame it does a ram read and an output
// load per payload byte, then the end marker, and waits while the result side stalls; for
// a bad checksum it loads the single error word.
// One 8-bit adder is shared between the running sum and the drain index.
module checksum_frame_receiver
   import cfr_pkg::*;
#(
   parameter int FRAME_BUFFER_BYTES = FRAME_BUFFER_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_frame_type,
   output logic [7:0]      rsp_payload_byte,
   output logic [4:0]      rsp_byte_index,
   output logic [4:0]      rsp_payload_length,
   output logic            rsp_last
);

   localparam int PAYLOAD_MAX = FRAME_BUFFER_BYTES - 5;
   localparam int RAM_DEPTH   = (PAYLOAD_MAX > 1) ? PAYLOAD_MAX : 1;
   localparam int ADDR_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam int POS_W       = $clog2(FRAME_BUFFER_BYTES);
   localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_MAX);

   localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC2  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(2);
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(3);
   localparam logic [POS_W-1:0] POS_DATA   = POS_W'(4);

   cfr_state_type state_ff, state_in;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        length_ff, length_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0]        final_kind_ff, final_kind_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff;
   logic [7:0]        rsp_type_ff;
   logic [7:0]        rsp_byte_ff;
   logic [4:0]        rsp_index_ff;
   logic [4:0]        rsp_length_ff;
   logic              rsp_last_ff;

   // control decoded by the sequencer
   logic              accept;
   logic              out_free;
   logic              load_payload;
   logic              load_final;
   logic [7:0]        add_a;
   logic [7:0]        add_b;
   logic [7:0]        add_sum;
   logic              drain_done;

   // byte step decode
   logic [POS_W-1:0]  csum_pos;
   logic [POS_W-1:0]  pos_off;
   logic              is_sync;
   logic              in_payload;
   logic              at_checksum;
   logic              csum_match;

   logic              ram_wr_en;
   logic [7:0]        ram_rd_data;
   logic [7:0]        idx_ext;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // position of the checksum byte; length is within the buffer whenever it is used
   assign csum_pos    = length_ff[POS_W-1:0] + POS_DATA;
   assign pos_off     = pos_ff - POS_DATA;
   assign is_sync     = (req_rx_byte == SYNC_BYTE);
   assign in_payload  = (pos_ff >= POS_DATA) && (pos_ff < csum_pos);
   assign at_checksum = (pos_ff >= POS_DATA) && (pos_ff == csum_pos);
   assign csum_match  = (req_rx_byte == sum_ff);

   // shared adder: running sum while receiving, drain index while emitting
   assign add_sum    = add_a + add_b;
   assign drain_done = (add_sum == length_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && at_checksum) begin
               if (csum_match && (length_ff != 8'd0)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = drain_done ? ST_FINAL : ST_READ;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      load_payload = 1'b0;
      load_final   = 1'b0;
      add_a        = sum_ff;
      add_b        = req_rx_byte;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_READ: begin
         end
         ST_LOAD: begin
            load_payload = out_free;
            add_a        = idx_ext;
            add_b        = 8'd1;
         end
         ST_FINAL: begin
            load_final = out_free;
         end
         default: begin
         end
      endcase
   end

   // frame parser: next values for one accepted byte
   always_comb begin
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      type_in       = type_ff;
      length_in     = length_ff;
      final_kind_in = final_kind_ff;
      ram_wr_en     = 1'b0;
      if (accept) begin
         priority if (pos_ff == POS_HUNT) begin
            if (is_sync) begin
               sum_in = SYNC_BYTE;
               pos_in = POS_SYNC2;
            end
         end else if (pos_ff == POS_SYNC2) begin
            if (is_sync) begin
               sum_in = add_sum;
               pos_in = POS_TYPE;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in = req_rx_byte;
            sum_in  = add_sum;
            pos_in  = POS_LENGTH;
         end else if (pos_ff == POS_LENGTH) begin
            length_in = req_rx_byte;
            sum_in    = add_sum;
            pos_in    = (req_rx_byte > LEN_LIMIT) ? POS_HUNT : POS_DATA;
         end else if (in_payload) begin
            ram_wr_en = 1'b1;
            sum_in    = add_sum;
            pos_in    = pos_ff + POS_W'(1);
         end else if (at_checksum) begin
            final_kind_in = csum_match ? KIND_END : KIND_ERROR;
            sum_in        = 8'd0;
            pos_in        = POS_HUNT;
         end else begin
            sum_in = 8'd0;
            pos_in = POS_HUNT;
         end
      end
   end

   // drain index
   always_comb begin
      idx_in = idx_ff;
      if (accept && at_checksum) begin
         idx_in = '0;
      end else if (load_payload) begin
         idx_in = add_sum[ADDR_W-1:0];
      end
   end

   assign idx_ext = 8'(idx_ff);

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_payload || load_final) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_HUNT;
         sum_ff       <= 8'd0;
         type_ff      <= 8'd0;
         length_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         type_ff      <= type_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      final_kind_ff <= final_kind_in;
      if (load_payload) begin
         rsp_kind_ff   <= KIND_PAYLOAD;
         rsp_type_ff   <= type_ff;
         rsp_byte_ff   <= ram_rd_data;
         rsp_index_ff  <= idx_ext[4:0];
         rsp_length_ff <= length_ff[4:0];
         rsp_last_ff   <= 1'b0;
      end else if (load_final) begin
         rsp_kind_ff   <= final_kind_ff;
         rsp_type_ff   <= type_ff;
         rsp_byte_ff   <= 8'd0;
         rsp_index_ff  <= 5'd0;
         rsp_length_ff <= length_ff[4:0];
         rsp_last_ff   <= 1'b1;
      end
   end

   // payload store
   cfr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(pos_off[ADDR_W-1:0]),
      .wr_data(req_rx_byte),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_frame_type     = rsp_type_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_byte_index     = rsp_index_ff;
   assign rsp_payload_length = rsp_length_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/cfr_checker.sv */
// cfr_port_checker: port-level checks on the checksum frame receiver
// depends on cfr_pkg; bound to checksum_frame_receiver at the end of this file
`default_nettype none

module cfr_port_checker
   import cfr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [4:0] rsp_byte_index,
   input wire logic       rsp_last
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last)
                                 && $stable(rsp_payload_byte) && $stable(rsp_byte_index))
      else $error("stalled result word changed");

   // end marker and error close the run, payload words never do
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_PAYLOAD)))
      else $error("last flag does not match result kind");

   // non-payload words carry zero byte and index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_PAYLOAD |-> rsp_payload_byte == 8'd0
                                                && rsp_byte_index == 5'd0)
      else $error("non-payload word has nonzero byte or index");

   // no byte is taken while a payload word of a frame drain is on the output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |-> !req_ready)
      else $error("input ready during payload drain");

endmodule

bind checksum_frame_receiver cfr_port_checker u_cfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_payload_byte(rsp_payload_byte),
   .rsp_byte_index  (rsp_byte_index),
   .rsp_last        (rsp_last)
);

`default_nettype wire
